>>> rtl/finger_presence_detector_assert.svh
// ----------------------------------------------------------------------------
// Finger presence detector assertion macros
// Shorthand for clocked checks that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FINGER_PRESENCE_DETECTOR_ASSERT_SVH
`define FINGER_PRESENCE_DETECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared widths, register map, reset values, divider constants and types.
// ----------------------------------------------------------------------------
package fpd_pkg;

	// sample and window widths
	localparam int SAMPLE_BITS = 18;
	localparam int WIN_BITS    = SAMPLE_BITS + 1;
	localparam int CNT_BITS    = 5;

	// APB port
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;
	localparam int REG_IDX_BITS  = 3;

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_IR_LEVEL     = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_RED_LEVEL    = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_LATCH_COUNT      = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_COUNTER_CEILING  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_PULSE_AMP    = 3'd4;

	// register reset values
	localparam logic [SAMPLE_BITS-1:0] RST_MIN_IR_LEVEL    = SAMPLE_BITS'(50000);
	localparam logic [SAMPLE_BITS-1:0] RST_MIN_RED_LEVEL   = SAMPLE_BITS'(2000);
	localparam logic [CNT_BITS-1:0]    RST_LATCH_COUNT     = CNT_BITS'(4);
	localparam logic [CNT_BITS-1:0]    RST_COUNTER_CEILING = CNT_BITS'(30);
	localparam logic [SAMPLE_BITS-1:0] RST_MIN_PULSE_AMP   = SAMPLE_BITS'(20);

	// counter drop on a weak sample
	localparam logic [CNT_BITS-1:0] WEAK_DROP = CNT_BITS'(3);

	// mid/500 by reciprocal: exact for any mid below 2^SAMPLE_BITS
	localparam int PULSE_DIV       = 500;
	localparam int DIV500_SHIFT    = SAMPLE_BITS + 9;
	localparam int DIV500_MUL_BITS = SAMPLE_BITS + 1;
	localparam logic [DIV500_MUL_BITS-1:0] DIV500_MUL =
		DIV500_MUL_BITS'((64'd1 << DIV500_SHIFT) / PULSE_DIV + 1);
	localparam int DIV500_PROD_BITS = SAMPLE_BITS + DIV500_MUL_BITS;

	// baseline filter: floor(d/200) with d biased up to stay non-negative
	localparam int BASE_DIV        = 200;
	localparam int BASE_W          = SAMPLE_BITS + 2;
	localparam int OFF_K           = (1 << SAMPLE_BITS) / BASE_DIV + 1;
	localparam logic [BASE_W-1:0] OFF_K_W    = BASE_W'(OFF_K);
	localparam logic [BASE_W-1:0] OFF_BIAS_W = BASE_W'(OFF_K * BASE_DIV);
	localparam int DIV200_SHIFT    = BASE_W + 8;
	localparam int DIV200_MUL_BITS = SAMPLE_BITS + 3;
	localparam logic [DIV200_MUL_BITS-1:0] DIV200_MUL =
		DIV200_MUL_BITS'((64'd1 << DIV200_SHIFT) / BASE_DIV + 1);
	localparam int DIV200_PROD_BITS = BASE_W + DIV200_MUL_BITS;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// configuration bundle
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] min_ir_level;
		logic [SAMPLE_BITS-1:0] min_red_level;
		logic [CNT_BITS-1:0]    latch_count;
		logic [CNT_BITS-1:0]    counter_ceiling;
		logic [SAMPLE_BITS-1:0] min_pulse_amplitude;
	} cfg_t;

	// classified sample
	typedef struct packed {
		logic                   is_strong;
		logic                   pulse;
		logic [SAMPLE_BITS-1:0] ir;
	} item_t;

	// queue status
	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [QCNT_BITS-1:0] count;
	} qstat_t;

endpackage

>>> rtl/fpd_regs.sv
// ----------------------------------------------------------------------------
// fpd_regs
// APB configuration registers with read back; zero wait states.
// ----------------------------------------------------------------------------
module fpd_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fpd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [fpd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [fpd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	output fpd_pkg::cfg_t                       cfg
);

	fpd_pkg::cfg_t                       cfg_q;
	logic [fpd_pkg::REG_IDX_BITS-1:0]    idx;
	logic                                wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[fpd_pkg::APB_ADDR_BITS-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_ir_level        <= fpd_pkg::RST_MIN_IR_LEVEL;
			cfg_q.min_red_level       <= fpd_pkg::RST_MIN_RED_LEVEL;
			cfg_q.latch_count         <= fpd_pkg::RST_LATCH_COUNT;
			cfg_q.counter_ceiling     <= fpd_pkg::RST_COUNTER_CEILING;
			cfg_q.min_pulse_amplitude <= fpd_pkg::RST_MIN_PULSE_AMP;
		end else if (wr_en) begin
			case (idx)
				fpd_pkg::REG_MIN_IR_LEVEL:
					cfg_q.min_ir_level <= pwdata[fpd_pkg::SAMPLE_BITS-1:0];
				fpd_pkg::REG_MIN_RED_LEVEL:
					cfg_q.min_red_level <= pwdata[fpd_pkg::SAMPLE_BITS-1:0];
				fpd_pkg::REG_LATCH_COUNT:
					cfg_q.latch_count <= pwdata[fpd_pkg::CNT_BITS-1:0];
				fpd_pkg::REG_COUNTER_CEILING:
					cfg_q.counter_ceiling <= pwdata[fpd_pkg::CNT_BITS-1:0];
				fpd_pkg::REG_MIN_PULSE_AMP:
					cfg_q.min_pulse_amplitude <= pwdata[fpd_pkg::SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			fpd_pkg::REG_MIN_IR_LEVEL:
				prdata = fpd_pkg::APB_DATA_BITS'(cfg_q.min_ir_level);
			fpd_pkg::REG_MIN_RED_LEVEL:
				prdata = fpd_pkg::APB_DATA_BITS'(cfg_q.min_red_level);
			fpd_pkg::REG_LATCH_COUNT:
				prdata = fpd_pkg::APB_DATA_BITS'(cfg_q.latch_count);
			fpd_pkg::REG_COUNTER_CEILING:
				prdata = fpd_pkg::APB_DATA_BITS'(cfg_q.counter_ceiling);
			fpd_pkg::REG_MIN_PULSE_AMP:
				prdata = fpd_pkg::APB_DATA_BITS'(cfg_q.min_pulse_amplitude);
			default:
				prdata = '0;
		endcase
	end

endmodule

>>> rtl/fpd_front.sv
// ----------------------------------------------------------------------------
// fpd_front
// Accepts sample words and classifies them as strong and as pulse evidence.
// ----------------------------------------------------------------------------
module fpd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpd_pkg::cfg_t                       cfg,
	input  logic                                push,
	output logic                                full,
	input  logic [fpd_pkg::SAMPLE_BITS-1:0]     ir_sample,
	input  logic [fpd_pkg::SAMPLE_BITS-1:0]     red_sample,
	input  logic signed [fpd_pkg::WIN_BITS-1:0] window_max,
	input  logic signed [fpd_pkg::WIN_BITS-1:0] window_min,
	input  logic                                q_full,
	output logic                                q_push,
	output fpd_pkg::item_t                      q_item
);

	localparam int S  = fpd_pkg::SAMPLE_BITS;
	localparam int PW = fpd_pkg::DIV500_PROD_BITS;

	logic                     advance;
	logic                     accept;
	logic signed [S+1:0]      sum;
	logic signed [S+1:0]      swing;
	logic                     amp_ok;
	logic                     is_strong;

	logic                     valid_s1;
	logic [S-1:0]             ir_s1;
	logic                     strong_s1;
	logic                     amp_ok_s1;
	logic signed [S:0]        mid_s1;
	logic signed [S+1:0]      swing_s1;

	logic [PW-1:0]            prod;
	logic [PW-1:0]            quo;
	logic                     pulse;

	// handshake: stage 1 moves when empty or when the queue takes its word
	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign accept  = push && advance;

	// window mid (floor) and swing at full signed width
	assign sum       = (S+2)'(window_max) + (S+2)'(window_min);
	assign swing     = (S+2)'(window_max) - (S+2)'(window_min);
	assign amp_ok    = !swing[S+1] && (swing[S:0] > {1'b0, cfg.min_pulse_amplitude});
	assign is_strong = (ir_sample > cfg.min_ir_level) && (red_sample > cfg.min_red_level);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ir_s1     <= ir_sample;
			strong_s1 <= is_strong;
			amp_ok_s1 <= amp_ok;
			mid_s1    <= sum[S+1:1];
			swing_s1  <= swing;
		end
	end

	// mid/500 by reciprocal multiply, then the pulse test
	assign prod  = PW'(mid_s1[S-1:0]) * PW'(fpd_pkg::DIV500_MUL);
	assign quo   = prod >> fpd_pkg::DIV500_SHIFT;
	assign pulse = !mid_s1[S] && (mid_s1 != '0) && amp_ok_s1 &&
		!swing_s1[S+1] && (PW'(swing_s1[S:0]) > quo);

	assign q_push           = valid_s1 && !q_full;
	assign q_item.is_strong = strong_s1;
	assign q_item.pulse     = pulse;
	assign q_item.ir        = ir_s1;

endmodule

>>> rtl/fpd_queue.sv
// ----------------------------------------------------------------------------
// fpd_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module fpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fpd_pkg::item_t din,
	input  logic           pop,
	output fpd_pkg::item_t dout,
	output fpd_pkg::qstat_t stat
);

	localparam int PB = fpd_pkg::QPTR_BITS;
	localparam int CB = fpd_pkg::QCNT_BITS;

	fpd_pkg::item_t          entry_q [fpd_pkg::QUEUE_DEPTH];
	logic [PB-1:0]           wr_ptr_q;
	logic [PB-1:0]           rd_ptr_q;
	logic [CB-1:0]           count_q;
	logic                    do_push;
	logic                    do_pop;

	assign stat.full  = (count_q == CB'(fpd_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(fpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(fpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> rtl/fpd_back.sv
// ----------------------------------------------------------------------------
// fpd_back
// Confidence counter, presence latch, IR baseline and the result register.
// ----------------------------------------------------------------------------
module fpd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fpd_pkg::cfg_t                    cfg,
	input  fpd_pkg::qstat_t                  q_stat,
	input  fpd_pkg::item_t                   q_item,
	output logic                             q_pop,
	output logic                             empty,
	input  logic                             pop,
	output logic                             finger_present,
	output logic [fpd_pkg::CNT_BITS-1:0]     confidence_count
);

	localparam int S  = fpd_pkg::SAMPLE_BITS;
	localparam int C  = fpd_pkg::CNT_BITS;
	localparam int BW = fpd_pkg::BASE_W;
	localparam int PW = fpd_pkg::DIV200_PROD_BITS;

	logic [C-1:0]   conf_q;
	logic           latch_q;
	logic [S-1:0]   base_q;
	logic           out_valid_q;
	logic           present_q;
	logic [C-1:0]   count_q;

	logic           take;
	logic           step;
	logic [C-1:0]   conf_n;
	logic           latch_n;
	logic           present_n;
	logic [BW-1:0]  biased;
	logic [PW-1:0]  prod;
	logic [BW-1:0]  quo;
	logic [BW-1:0]  filt;
	logic [S-1:0]   base_n;

	// take the next word when the result register is free or being drained
	assign take  = !q_stat.empty && (!out_valid_q || pop);
	assign q_pop = take;
	assign empty = !out_valid_q;

	// step above the learned baseline
	assign step = (base_q != '0) &&
		({1'b0, q_item.ir} > ({1'b0, base_q} + {1'b0, cfg.min_ir_level}));

	// counter and latch update
	always_comb begin
		conf_n    = conf_q;
		latch_n   = latch_q;
		present_n = 1'b0;
		if (q_item.is_strong) begin
			if (step || q_item.pulse) begin
				if (conf_q < cfg.counter_ceiling) begin
					conf_n = conf_q + 1'b1;
				end
			end else if (conf_q != '0) begin
				conf_n = conf_q - 1'b1;
			end
			if (conf_n >= cfg.latch_count) begin
				latch_n = 1'b1;
			end
			if (conf_n == '0) begin
				latch_n = 1'b0;
			end
			present_n = latch_n;
		end else begin
			conf_n = (conf_q > fpd_pkg::WEAK_DROP) ? conf_q - fpd_pkg::WEAK_DROP : '0;
			if (conf_n == '0) begin
				latch_n = 1'b0;
			end
		end
	end

	// baseline filter: b + floor((ir - b)/200), divided by reciprocal multiply
	assign biased = BW'(q_item.ir) - BW'(base_q) + fpd_pkg::OFF_BIAS_W;
	assign prod   = PW'(biased) * PW'(fpd_pkg::DIV200_MUL);
	assign quo    = BW'(prod >> fpd_pkg::DIV200_SHIFT);
	assign filt   = BW'(base_q) + quo - fpd_pkg::OFF_K_W;

	always_comb begin
		base_n = base_q;
		if (conf_n == '0) begin
			if ((base_q == '0) && (q_item.ir > cfg.min_ir_level)) begin
				base_n = q_item.ir;
			end else begin
				base_n = filt[S-1:0];
			end
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q      <= '0;
			latch_q     <= 1'b0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				conf_q  <= conf_n;
				latch_q <= latch_n;
				base_q  <= base_n;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			present_q <= present_n;
			count_q   <= conf_n;
		end
	end

	assign finger_present   = present_q;
	assign confidence_count = count_q;

endmodule

>>> rtl/finger_presence_detector.sv
// ----------------------------------------------------------------------------
// finger_presence_detector
// Judges finger presence on an optical sensor from a stream of samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive a sample word (ir_sample, red_sample, window_max,
//   window_min) with push; the word is taken on a clock edge with push high
//   and full low. Result channel: while empty is low the oldest result
//   (finger_present, confidence_count) is on the ports; pop with empty low
//   takes it. One result per sample word, in order.
//   Throughput: one word per cycle while pop stays high. A taken word passes
//   one classify register stage in the front, then the queue; the back
//   updates its state as it loads the result register. The counter and
//   baseline loop in the back is combinational between its registers.
//   Stall: if pop is held low, the result register holds, the four-word
//   queue fills behind it, and full rises once the front stage is blocked.
//   Reset (arst_n low): counter, latch and baseline clear, queue and result
//   register empty, registers take their default values. Configuration is
//   to be written over APB only while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
`include "finger_presence_detector_assert.svh"

module finger_presence_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fpd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [fpd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [fpd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	input  logic                                push,
	output logic                                full,
	input  logic [fpd_pkg::SAMPLE_BITS-1:0]     ir_sample,
	input  logic [fpd_pkg::SAMPLE_BITS-1:0]     red_sample,
	input  logic signed [fpd_pkg::WIN_BITS-1:0] window_max,
	input  logic signed [fpd_pkg::WIN_BITS-1:0] window_min,
	output logic                                empty,
	input  logic                                pop,
	output logic                                finger_present,
	output logic [fpd_pkg::CNT_BITS-1:0]        confidence_count
);

	fpd_pkg::cfg_t   cfg;
	fpd_pkg::item_t  front_item;
	fpd_pkg::item_t  head_item;
	fpd_pkg::qstat_t q_stat;
	logic            q_push;
	logic            q_pop;

	// configuration registers
	fpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: accept and classify
	fpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.push       (push),
		.full       (full),
		.ir_sample  (ir_sample),
		.red_sample (red_sample),
		.window_max (window_max),
		.window_min (window_min),
		.q_full     (q_stat.full),
		.q_push     (q_push),
		.q_item     (front_item)
	);

	// decoupling queue
	fpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (front_item),
		.pop    (q_pop),
		.dout   (head_item),
		.stat   (q_stat)
	);

	// back: state update and result word
	fpd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.q_stat           (q_stat),
		.q_item           (head_item),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.finger_present   (finger_present),
		.confidence_count (confidence_count)
	);

	// checks
	`FPD_ASSERT_SAME(a_present_needs_count, !empty && finger_present, confidence_count != '0, "presence reported with zero count")
	`FPD_ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count <= fpd_pkg::QCNT_BITS'(fpd_pkg::QUEUE_DEPTH), "queue count past depth")
	`FPD_ASSERT_NEXT(a_result_loads, empty && !q_stat.empty, !empty, "queued word not moved to result register")

endmodule
